// ===== hdl/pts_pkg.sv =====
`default_nettype none

package pts_pkg;

  // field widths of the item channels
  localparam int unsigned ModeW   = 2;
  localparam int unsigned PrioW   = 8;
  localparam int unsigned DelayW  = 32;
  localparam int unsigned TickW   = 32;
  localparam int unsigned ChosenW = 4;

  // item modes
  localparam logic [ModeW-1:0] MODE_TICK  = 2'd0;
  localparam logic [ModeW-1:0] MODE_ADD   = 2'd1;
  localparam logic [ModeW-1:0] MODE_DELAY = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic exec_item;
    logic scan_start;
    logic scan_step;
    logic finish_tick;
  } pts_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_tick;
    logic scan_done;
    logic out_free;
  } pts_status_t;

endpackage

`default_nettype wire

// ===== hdl/pts_if.sv =====
`default_nettype none

interface pts_in_if;
  logic                          valid;
  logic                          ready;
  logic [pts_pkg::ModeW-1:0]     mode;
  logic [pts_pkg::PrioW-1:0]     priority_req;
  logic [pts_pkg::DelayW-1:0]    delay_count;

  modport source (output valid, output mode, output priority_req, output delay_count,
                  input ready);
  modport sink (input valid, input mode, input priority_req, input delay_count,
                output ready);
endinterface

interface pts_out_if;
  logic                          valid;
  logic                          ready;
  logic [pts_pkg::ChosenW-1:0]   chosen_task;
  logic                          idle;
  logic                          accepted;
  logic [pts_pkg::TickW-1:0]     tick_number;

  modport source (output valid, output chosen_task, output idle, output accepted,
                  output tick_number, input ready);
  modport sink (input valid, input chosen_task, input idle, input accepted,
                input tick_number, output ready);
endinterface

`default_nettype wire

// ===== hdl/pts_ctrl.sv =====
`default_nettype none

module pts_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  pts_pkg::pts_status_t status_i,
  output pts_pkg::pts_cmd_t    cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status_i.is_tick) begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_SCAN;
        end else if (status_i.out_free) begin
          cmd_o.exec_item = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_SCAN: begin
        if (status_i.scan_done) begin
          state_d = S_DONE;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.finish_tick = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_scan_enters_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && $past(state_q) != S_SCAN) |-> $past(state_q) == S_EXEC)
    else $error("scan entered from a state other than exec");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one datapath command at once");

  a_done_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && $past(state_q) != S_DONE) |-> $past(status_i.scan_done))
    else $error("tick finished before the scan was done");
`endif

endmodule

`default_nettype wire

// ===== hdl/pts_datapath.sv =====
`default_nettype none

module pts_datapath #(
  parameter int unsigned NUM_TASKS = 16
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  pts_pkg::pts_cmd_t             cmd_i,
  output pts_pkg::pts_status_t          status_o,
  input  wire [pts_pkg::ModeW-1:0]      in_mode_i,
  input  wire [pts_pkg::PrioW-1:0]      in_priority_req_i,
  input  wire [pts_pkg::DelayW-1:0]     in_delay_count_i,
  input  wire                           out_ready_i,
  output logic                          out_valid_o,
  output logic [pts_pkg::ChosenW-1:0]   out_chosen_task_o,
  output logic                          out_idle_o,
  output logic                          out_accepted_o,
  output logic [pts_pkg::TickW-1:0]     out_tick_number_o
);

  localparam int unsigned IdxW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int unsigned CntW = $clog2(NUM_TASKS + 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(NUM_TASKS);

  // latched item
  logic [pts_pkg::ModeW-1:0]  mode_q;
  logic [pts_pkg::PrioW-1:0]  prio_q;
  logic [pts_pkg::DelayW-1:0] count_q;

  // scheduler state
  logic [CntW-1:0]           used_q, used_d;
  logic                      cur_valid_q, cur_valid_d;
  logic [IdxW-1:0]           cur_idx_q, cur_idx_d;
  logic [pts_pkg::TickW-1:0] tick_q, tick_d;
  logic [NUM_TASKS-1:0]      blocked_q, blocked_d;

  // task tables
  logic [pts_pkg::PrioW-1:0]  prio_mem [NUM_TASKS];
  logic [pts_pkg::DelayW-1:0] delay_mem [NUM_TASKS];
  logic [pts_pkg::PrioW-1:0]  prio_rd_q;
  logic [pts_pkg::DelayW-1:0] delay_rd_q;

  logic                       prio_we, delay_we;
  logic [IdxW-1:0]            prio_wa, delay_wa;
  logic [pts_pkg::DelayW-1:0] delay_wd;

  // scan pipeline
  logic [CntW-1:0]           rd_cnt_q, rd_cnt_d;
  logic                      proc_valid_q, proc_valid_d;
  logic [IdxW-1:0]           proc_idx_q, proc_idx_d;
  logic                      found_q, found_d;
  logic [IdxW-1:0]           best_idx_q, best_idx_d;
  logic [pts_pkg::PrioW-1:0] best_prio_q, best_prio_d;
  logic                      rd_go;
  logic [IdxW-1:0]           rd_addr;
  logic                      proc_blk;
  logic [pts_pkg::DelayW-1:0] next_delay;
  logic                      proc_ready;

  // result register
  logic                        out_valid_q, out_valid_d;
  logic [pts_pkg::ChosenW-1:0] out_chosen_q, out_chosen_d;
  logic                        out_idle_q, out_idle_d;
  logic                        out_acc_q, out_acc_d;
  logic [pts_pkg::TickW-1:0]   out_tick_q;
  logic                        out_load;
  logic                        out_free;
  logic                        table_full;

  assign out_free   = !out_valid_q || out_ready_i;
  assign table_full = (used_q >= FullCnt);
  assign rd_go      = cmd_i.scan_step && (rd_cnt_q < used_q);
  assign rd_addr    = rd_cnt_q[IdxW-1:0];

  assign status_o.is_tick   = (mode_q == pts_pkg::MODE_TICK);
  assign status_o.scan_done = (rd_cnt_q >= used_q) && !proc_valid_q;
  assign status_o.out_free  = out_free;

  // wake-up check for the entry coming out of the tables
  always_comb begin
    proc_blk   = blocked_q[proc_idx_q];
    next_delay = delay_rd_q - ((delay_rd_q != '0) ? pts_pkg::DelayW'(1) : '0);
    proc_ready = !proc_blk || (next_delay == '0);
  end

  always_comb begin
    used_d       = used_q;
    cur_valid_d  = cur_valid_q;
    cur_idx_d    = cur_idx_q;
    tick_d       = tick_q;
    blocked_d    = blocked_q;
    rd_cnt_d     = rd_cnt_q;
    proc_valid_d = proc_valid_q;
    proc_idx_d   = proc_idx_q;
    found_d      = found_q;
    best_idx_d   = best_idx_q;
    best_prio_d  = best_prio_q;
    prio_we      = 1'b0;
    prio_wa      = '0;
    delay_we     = 1'b0;
    delay_wa     = '0;
    delay_wd     = '0;
    out_load     = 1'b0;
    out_chosen_d = '0;
    out_idle_d   = 1'b0;
    out_acc_d    = 1'b0;

    if (cmd_i.exec_item) begin
      out_load = 1'b1;
      if (mode_q == pts_pkg::MODE_ADD && !table_full) begin
        prio_we                       = 1'b1;
        prio_wa                       = used_q[IdxW-1:0];
        delay_we                      = 1'b1;
        delay_wa                      = used_q[IdxW-1:0];
        blocked_d[used_q[IdxW-1:0]]   = 1'b0;
        used_d                        = used_q + CntW'(1);
        out_chosen_d                  = pts_pkg::ChosenW'(used_q[IdxW-1:0]);
        out_acc_d                     = 1'b1;
      end else if (mode_q == pts_pkg::MODE_DELAY && cur_valid_q) begin
        delay_we             = 1'b1;
        delay_wa             = cur_idx_q;
        delay_wd             = count_q;
        blocked_d[cur_idx_q] = 1'b1;
        out_chosen_d         = pts_pkg::ChosenW'(cur_idx_q);
        out_acc_d            = 1'b1;
      end
    end

    if (cmd_i.scan_start) begin
      tick_d       = tick_q + pts_pkg::TickW'(1);
      rd_cnt_d     = '0;
      proc_valid_d = 1'b0;
      found_d      = 1'b0;
    end

    if (cmd_i.scan_step) begin
      proc_valid_d = rd_go;
      proc_idx_d   = rd_addr;
      if (rd_go) begin
        rd_cnt_d = rd_cnt_q + CntW'(1);
      end
      if (proc_valid_q) begin
        if (proc_blk) begin
          delay_we = 1'b1;
          delay_wa = proc_idx_q;
          delay_wd = next_delay;
          if (next_delay == '0) begin
            blocked_d[proc_idx_q] = 1'b0;
          end
        end
        if (proc_ready && (!found_q || prio_rd_q < best_prio_q)) begin
          found_d     = 1'b1;
          best_idx_d  = proc_idx_q;
          best_prio_d = prio_rd_q;
        end
      end
    end

    if (cmd_i.finish_tick) begin
      out_load  = 1'b1;
      out_acc_d = 1'b1;
      if (found_q) begin
        cur_valid_d  = 1'b1;
        cur_idx_d    = best_idx_q;
        out_chosen_d = pts_pkg::ChosenW'(best_idx_q);
      end else begin
        out_idle_d = 1'b1;
      end
    end

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // task tables, one write and one registered read per cycle each
  always_ff @(posedge clk_i) begin
    if (prio_we) begin
      prio_mem[prio_wa] <= prio_q;
    end
    if (rd_go) begin
      prio_rd_q <= prio_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (delay_we) begin
      delay_mem[delay_wa] <= delay_wd;
    end
    if (rd_go) begin
      delay_rd_q <= delay_mem[rd_addr];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      mode_q  <= in_mode_i;
      prio_q  <= in_priority_req_i;
      count_q <= in_delay_count_i;
    end
    proc_idx_q  <= proc_idx_d;
    best_idx_q  <= best_idx_d;
    best_prio_q <= best_prio_d;
    if (out_load) begin
      out_chosen_q <= out_chosen_d;
      out_idle_q   <= out_idle_d;
      out_acc_q    <= out_acc_d;
      // tick count as of this item, held while the result waits
      out_tick_q   <= tick_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q       <= '0;
      cur_valid_q  <= 1'b0;
      cur_idx_q    <= '0;
      tick_q       <= '0;
      blocked_q    <= '0;
      rd_cnt_q     <= '0;
      proc_valid_q <= 1'b0;
      found_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      used_q       <= used_d;
      cur_valid_q  <= cur_valid_d;
      cur_idx_q    <= cur_idx_d;
      tick_q       <= tick_d;
      blocked_q    <= blocked_d;
      rd_cnt_q     <= rd_cnt_d;
      proc_valid_q <= proc_valid_d;
      found_q      <= found_d;
      out_valid_q  <= out_valid_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_chosen_task_o = out_chosen_q;
  assign out_idle_o        = out_idle_q;
  assign out_accepted_o    = out_acc_q;
  assign out_tick_number_o = out_tick_q;

`ifndef NO_ASSERTIONS
  a_used_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= FullCnt)
    else $error("task count above table size");

  a_current_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> (CntW'(cur_idx_q) < used_q))
    else $error("current task outside the used slots");

  a_proc_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_valid_q |-> (CntW'(proc_idx_q) < used_q))
    else $error("scan touched an unused slot");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register loaded while a result still waits");
`endif

endmodule

`default_nettype wire

// ===== hdl/priority_task_scheduler_core.sv =====
// priority task scheduler: a table of up to NUM_TASKS tasks with 8-bit priorities
// input channel in_i carries one item per handshake: mode selects tick, add task
// or delay current task; priority_req is used by add, delay_count by delay
// output channel out_o returns exactly one result item per input item:
// chosen_task, idle, accepted and the tick counter after the item, all registered
// add and delay items load the result register from the execute state once the
// output register is free; the controller then returns to idle for the next item
// a tick moves from execute to a scan state and then to a done state that loads
// its result once the output register is free; the scan reads one task entry a cycle
// through the priority and delay tables (one registered read port each),
// counting down delays and tracking the best ready task as it goes
// one item is in work at a time; a new item is taken as soon as the previous
// result sits in the output register, even while that result is still stalled
// if the receiver stalls, a finished result waits and the item behind it
// holds until the output register frees up; nothing is dropped
// reset clears the task count, blocked flags, current task and tick counter;
// table contents are only read below the task count and need no clearing
`default_nettype none

module priority_task_scheduler_core #(
  parameter int unsigned NUM_TASKS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  pts_in_if.sink      in_i,
  pts_out_if.source   out_o
);

  pts_pkg::pts_cmd_t    cmd;
  pts_pkg::pts_status_t status;
  logic                 in_ready;

  // sequencing of item phases: latch, execute or scan, result
  pts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // task tables, scan pipeline and result register
  pts_datapath #(
    .NUM_TASKS (NUM_TASKS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .in_mode_i         (in_i.mode),
    .in_priority_req_i (in_i.priority_req),
    .in_delay_count_i  (in_i.delay_count),
    .out_ready_i       (out_o.ready),
    .out_valid_o       (out_o.valid),
    .out_chosen_task_o (out_o.chosen_task),
    .out_idle_o        (out_o.idle),
    .out_accepted_o    (out_o.accepted),
    .out_tick_number_o (out_o.tick_number)
  );

  assign in_i.ready = in_ready;

endmodule

`default_nettype wire

// ===== test/tb_priority_task_scheduler_core.sv =====
`default_nettype none

localparam int unsigned TaskSlots = 16;

// one result item as the block should return it
typedef struct packed {
  logic [pts_pkg::ChosenW-1:0] chosen_task;
  logic                        idle;
  logic                        accepted;
  logic [pts_pkg::TickW-1:0]   tick_number;
} sched_outcome_t;

// shadow task table plus the queue of outcomes still owed by the block
class sched_scoreboard;
  bit                        task_asleep[TaskSlots];
  logic [pts_pkg::PrioW-1:0] task_prio[TaskSlots];
  logic [pts_pkg::DelayW-1:0] sleep_left[TaskSlots];
  int unsigned               tasks_used;
  bit                        running_valid;
  int unsigned               running_idx;
  logic [pts_pkg::TickW-1:0] ticks_seen;
  sched_outcome_t            owed_outcomes[$];
  int unsigned               failures;

  function new();
    foreach (task_asleep[i]) begin
      task_asleep[i] = 1'b0;
      task_prio[i]   = '0;
      sleep_left[i]  = '0;
    end
    tasks_used    = 0;
    running_valid = 1'b0;
    running_idx   = 0;
    ticks_seen    = '0;
    failures      = 0;
  endfunction

  // advance the shadow table by one accepted item and queue its outcome
  function void note_item(logic [pts_pkg::ModeW-1:0] mode, logic [pts_pkg::PrioW-1:0] prio,
                          logic [pts_pkg::DelayW-1:0] sleep_ticks);
    sched_outcome_t o;
    int unsigned    best;
    bit             found;
    o     = '0;
    best  = 0;
    found = 1'b0;
    case (mode)
      pts_pkg::MODE_TICK: begin
        ticks_seen++;
        for (int unsigned i = 0; i < tasks_used; i++) begin
          if (task_asleep[i]) begin
            if (sleep_left[i] != 0) sleep_left[i]--;
            if (sleep_left[i] == 0) task_asleep[i] = 1'b0;
          end
        end
        for (int unsigned i = 0; i < tasks_used; i++) begin
          if (!task_asleep[i] && (!found || task_prio[i] < task_prio[best])) begin
            best  = i;
            found = 1'b1;
          end
        end
        o.accepted = 1'b1;
        if (found) begin
          running_valid = 1'b1;
          running_idx   = best;
          o.chosen_task = best[pts_pkg::ChosenW-1:0];
        end else begin
          // nothing ready: report idle, previous task stays current
          o.idle = 1'b1;
        end
      end
      pts_pkg::MODE_ADD: begin
        if (tasks_used < TaskSlots) begin
          task_asleep[tasks_used] = 1'b0;
          task_prio[tasks_used]   = prio;
          sleep_left[tasks_used]  = '0;
          o.chosen_task = tasks_used[pts_pkg::ChosenW-1:0];
          o.accepted    = 1'b1;
          tasks_used++;
        end
      end
      pts_pkg::MODE_DELAY: begin
        if (running_valid) begin
          // a sleeping task gets its count reloaded
          task_asleep[running_idx] = 1'b1;
          sleep_left[running_idx]  = sleep_ticks;
          o.chosen_task = running_idx[pts_pkg::ChosenW-1:0];
          o.accepted    = 1'b1;
        end
      end
      default: ;
    endcase
    o.tick_number = ticks_seen;
    owed_outcomes.push_back(o);
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      failures++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  function void check_result(logic [pts_pkg::ChosenW-1:0] chosen_task, logic idle,
                             logic accepted, logic [pts_pkg::TickW-1:0] tick_number);
    sched_outcome_t e;
    if (owed_outcomes.size() == 0) begin
      failures++;
      $display("%0t: result with no item pending, expected none actual chosen %0d tick %0d",
               $time, chosen_task, tick_number);
      return;
    end
    e = owed_outcomes.pop_front();
    compare_field("chosen_task", 32'(e.chosen_task), 32'(chosen_task));
    compare_field("idle", 32'(e.idle), 32'(idle));
    compare_field("accepted", 32'(e.accepted), 32'(accepted));
    compare_field("tick_number", e.tick_number, tick_number);
  endfunction
endclass

module tb_priority_task_scheduler_core;

  localparam logic [pts_pkg::ModeW-1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned RandomItems = 600;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 60;
  // receiver hold-off and calm stretch, in receiver cycles
  localparam int unsigned HoldStart  = 3000;
  localparam int unsigned HoldLength = 500;
  localparam int unsigned CalmStart  = 6000;
  localparam int unsigned CalmLength = 3000;

  logic clk_i;
  logic rst_ni;

  pts_in_if  in_ch ();
  pts_out_if out_ch ();

  sched_scoreboard sb;

  priority_task_scheduler_core #(
    .NUM_TASKS(TaskSlots)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = '0;
    in_ch.priority_req = '0;
    in_ch.delay_count = '0;
    out_ch.ready = 1'b0;
    sb = new();
  end

  always #5 clk_i = ~clk_i;

  // mostly short sleeps so tasks keep waking, now and then a very long one
  function automatic logic [pts_pkg::DelayW-1:0] pick_sleep();
    int unsigned r;
    r = $urandom_range(0, 199);
    if (r == 0) return $urandom;
    if (r < 12) return $urandom_range(7, 40);
    return $urandom_range(0, 6);
  endfunction

  // offer one item and hold it until the block takes it
  task automatic send_item(input logic [pts_pkg::ModeW-1:0] mode,
                           input logic [pts_pkg::PrioW-1:0] prio,
                           input logic [pts_pkg::DelayW-1:0] sleep_ticks,
                           input bit may_idle);
    if (may_idle && $urandom_range(0, 99) < 16) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < 16);
    end
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= mode;
    in_ch.priority_req <= prio;
    in_ch.delay_count  <= sleep_ticks;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_item(mode, prio, sleep_ticks);
  endtask

  // result side: random stalls, one long hold-off, one calm stretch
  initial begin
    int unsigned rx_cycle;
    rx_cycle = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.chosen_task, out_ch.idle, out_ch.accepted,
                        out_ch.tick_number);
      rx_cycle++;
      if (rx_cycle >= HoldStart && rx_cycle < HoldStart + HoldLength)
        out_ch.ready <= 1'b0;
      else if (rx_cycle >= CalmStart && rx_cycle < CalmStart + CalmLength)
        out_ch.ready <= 1'b1;
      else
        out_ch.ready <= ($urandom_range(0, 99) >= 16);
    end
  end

  // watchdog
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    int unsigned n;
    int unsigned pick;
    bit          calm;
    n = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    send_item(pts_pkg::MODE_DELAY, 8'd0, 32'd5, 1'b1);          // no current task yet
    send_item(pts_pkg::MODE_TICK, 8'd0, 32'd0, 1'b1);           // empty table ticks idle
    send_item(MODE_UNUSED, 8'hff, 32'hffff_ffff, 1'b1);         // unknown mode ignored
    send_item(pts_pkg::MODE_ADD, 8'hff, 32'd0, 1'b1);
    send_item(pts_pkg::MODE_ADD, 8'h00, 32'd0, 1'b1);
    send_item(pts_pkg::MODE_ADD, 8'h00, 32'd0, 1'b1);           // tie, lower slot wins
    send_item(pts_pkg::MODE_ADD, 8'h80, 32'd0, 1'b1);
    send_item(pts_pkg::MODE_TICK, 8'd0, 32'd0, 1'b1);
    send_item(pts_pkg::MODE_DELAY, 8'd0, 32'd0, 1'b1);          // zero delay wakes next tick
    send_item(pts_pkg::MODE_TICK, 8'd0, 32'd0, 1'b1);
    send_item(pts_pkg::MODE_DELAY, 8'd0, 32'd3, 1'b1);
    send_item(pts_pkg::MODE_DELAY, 8'd0, 32'd2, 1'b1);          // reload while asleep
    send_item(pts_pkg::MODE_TICK, 8'd0, 32'd0, 1'b1);
    send_item(pts_pkg::MODE_DELAY, 8'd0, 32'hffff_ffff, 1'b1);  // longest sleep
    send_item(pts_pkg::MODE_TICK, 8'd0, 32'd0, 1'b1);
    send_item(pts_pkg::MODE_TICK, 8'd0, 32'd0, 1'b1);
    send_item(pts_pkg::MODE_DELAY, 8'd0, 32'd1, 1'b1);
    send_item(pts_pkg::MODE_TICK, 8'd0, 32'd0, 1'b1);
    send_item(pts_pkg::MODE_DELAY, 8'd0, 32'd4, 1'b1);
    send_item(pts_pkg::MODE_TICK, 8'd0, 32'd0, 1'b1);
    send_item(pts_pkg::MODE_DELAY, 8'd0, 32'd4, 1'b1);
    send_item(pts_pkg::MODE_TICK, 8'd0, 32'd0, 1'b1);
    send_item(pts_pkg::MODE_DELAY, 8'd0, 32'd4, 1'b1);
    send_item(pts_pkg::MODE_TICK, 8'd0, 32'd0, 1'b1);           // all asleep, idle tick
    send_item(pts_pkg::MODE_DELAY, 8'd0, 32'd1, 1'b1);          // hits previous current task

    // random part: mostly tick then delay, as a task body would, plus noise
    while (n < RandomItems) begin
      calm = (n >= 300 && n < 420);
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        // keeps adding past a full table
        send_item(pts_pkg::MODE_ADD, 8'($urandom), $urandom, !calm);
        n++;
      end else if (pick < 15) begin
        send_item(MODE_UNUSED, 8'($urandom), $urandom, !calm);
        n++;
      end else if (pick < 19) begin
        send_item(pts_pkg::MODE_DELAY, 8'($urandom), pick_sleep(), !calm);
        n++;
      end else begin
        send_item(pts_pkg::MODE_TICK, 8'($urandom), $urandom, !calm);
        n++;
        if ($urandom_range(0, 99) < 60) begin
          send_item(pts_pkg::MODE_DELAY, 8'($urandom), pick_sleep(), !calm);
          n++;
          if ($urandom_range(0, 99) < 10) begin
            send_item(pts_pkg::MODE_DELAY, 8'($urandom), pick_sleep(), !calm);
            n++;
          end
        end
      end
    end
    in_ch.valid <= 1'b0;

    while (sb.owed_outcomes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.failures == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/pts_pkg.sv
hdl/pts_if.sv
hdl/pts_ctrl.sv
hdl/pts_datapath.sv
hdl/priority_task_scheduler_core.sv
test/tb_priority_task_scheduler_core.sv
